// File: hw/rtl/swpe_pkg.sv
// Shared types and constants for the swapped-pair field encoder.
// No dependencies; imported by the input and result interfaces and every module of the block.
package swpe_pkg;

    localparam int VAL_W   = 32;
    localparam int CTRL_W  = 8;
    localparam int RES_MAX = 4;
    localparam int CNT_W   = $clog2(RES_MAX + 1);
    localparam int IDX_W   = $clog2(RES_MAX);

    localparam logic [VAL_W-1:0] MASK_16 = 32'h0000_FFFF;
    localparam logic [VAL_W-1:0] MASK_32 = 32'hFFFF_FFFF;

    localparam logic [2:0]        BIT_LAST  = 3'd7;
    localparam logic [CTRL_W-1:0] CTRL_MSB  = 8'h80;

    // result kinds
    localparam logic KIND_RESIDUAL = 1'b0;
    localparam logic KIND_CTRL     = 1'b1;

    // width_mode codes
    localparam logic MODE_16 = 1'b0;
    localparam logic MODE_32 = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [VAL_W-1:0] value;
        logic             final_res;
    } t_res;

    typedef struct packed {
        t_res [RES_MAX-1:0] ent;
        logic [CNT_W-1:0]   cnt;
    } t_res_list;

    function automatic t_res make_res(input logic kind, input logic [VAL_W-1:0] value);
        t_res r;
        r.kind      = kind;
        r.value     = value;
        r.final_res = 1'b0;
        return r;
    endfunction

endpackage

// File: hw/rtl/swpe_in_if.sv
// Input record channel: valid/ready handshake with the two paired fields.
// Depends on swpe_pkg.
interface swpe_in_if import swpe_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] first_value;
    logic [VAL_W-1:0] second_value;
    logic             last_record;

    modport source (output valid, first_value, second_value, last_record, input ready);
    modport sink   (input valid, first_value, second_value, last_record, output ready);
endinterface

// File: hw/rtl/swpe_out_if.sv
// Result channel: valid/ready handshake carrying kind, value and final flag.
// Depends on swpe_pkg.
interface swpe_out_if import swpe_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [VAL_W-1:0] value;
    logic             final_res;

    modport source (output valid, kind, value, final_res, input ready);
    modport sink   (input valid, kind, value, final_res, output ready);
endinterface

// File: hw/rtl/swpe_cfg_if.sv
// Configuration write channel for the width_mode register.
// No dependencies.
interface swpe_cfg_if ();
    logic valid;
    logic ready;
    logic width_mode;

    modport source (output valid, width_mode, input ready);
    modport sink   (input valid, width_mode, output ready);
endinterface

// File: hw/rtl/swpe_core.sv
// Pairing state, control-bit packer and the per-request result list.
// Depends on swpe_pkg.
module swpe_core import swpe_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_mode,
    input  logic             i_accept,
    input  logic [VAL_W-1:0] i_first_value,
    input  logic [VAL_W-1:0] i_second_value,
    input  logic             i_last_record,
    output t_res_list        o_list
);

    logic              r_width_mode;
    logic [VAL_W-1:0]  r_pend_first,  n_pend_first;
    logic [VAL_W-1:0]  r_pend_second, n_pend_second;
    logic              r_pend_valid,  n_pend_valid;
    logic [CTRL_W-1:0] r_ctrl_bits,   n_ctrl_bits;
    logic [2:0]        r_bit_cnt,     n_bit_cnt;

    always_comb begin
        logic [VAL_W-1:0]  m;
        logic [VAL_W-1:0]  pf;
        logic [VAL_W-1:0]  ps;
        logic              pv;
        logic [CTRL_W-1:0] cb;
        logic [2:0]        bc;
        logic [CNT_W-1:0]  n;
        logic [CNT_W-1:0]  nl;
        t_res_list         lst;

        m   = (r_width_mode == MODE_32) ? MASK_32 : MASK_16;
        pf  = r_pend_first;
        ps  = r_pend_second;
        pv  = r_pend_valid;
        cb  = r_ctrl_bits;
        bc  = r_bit_cnt;
        n   = '0;
        nl  = '0;
        lst = '0;

        if (pv) begin
            if ((((pf ^ i_second_value) & m) == '0) && (((ps ^ i_first_value) & m) == '0)) begin
                // swapped pair: one set bit, both second fields dropped
                pv = 1'b0;
                cb = cb | (CTRL_MSB >> bc);
                if (bc == BIT_LAST) begin
                    lst.ent[n[IDX_W-1:0]] = make_res(KIND_CTRL, {{(VAL_W-CTRL_W){1'b0}}, cb});
                    n  = n + 1'b1;
                    cb = '0;
                    bc = '0;
                end else begin
                    bc = bc + 1'b1;
                end
            end else begin
                lst.ent[n[IDX_W-1:0]] = make_res(KIND_RESIDUAL, ps & m);
                n = n + 1'b1;
                if (bc == BIT_LAST) begin
                    lst.ent[n[IDX_W-1:0]] = make_res(KIND_CTRL, {{(VAL_W-CTRL_W){1'b0}}, cb});
                    n  = n + 1'b1;
                    cb = '0;
                    bc = '0;
                end else begin
                    bc = bc + 1'b1;
                end
                pf = i_first_value;
                ps = i_second_value;
            end
        end else begin
            pf = i_first_value;
            ps = i_second_value;
            pv = 1'b1;
        end

        if (i_last_record) begin
            // flush the pending record as unpaired, then any partial byte
            if (pv) begin
                lst.ent[n[IDX_W-1:0]] = make_res(KIND_RESIDUAL, ps & m);
                n = n + 1'b1;
                if (bc == BIT_LAST) begin
                    lst.ent[n[IDX_W-1:0]] = make_res(KIND_CTRL, {{(VAL_W-CTRL_W){1'b0}}, cb});
                    n  = n + 1'b1;
                    cb = '0;
                    bc = '0;
                end else begin
                    bc = bc + 1'b1;
                end
            end
            if (bc != '0) begin
                lst.ent[n[IDX_W-1:0]] = make_res(KIND_CTRL, {{(VAL_W-CTRL_W){1'b0}}, cb});
                n = n + 1'b1;
            end
            if (n != '0) begin
                nl = n - 1'b1;
                lst.ent[nl[IDX_W-1:0]].final_res = 1'b1;
            end
            pf = '0;
            ps = '0;
            pv = 1'b0;
            cb = '0;
            bc = '0;
        end

        lst.cnt       = n;
        o_list        = lst;
        n_pend_first  = pf;
        n_pend_second = ps;
        n_pend_valid  = pv;
        n_ctrl_bits   = cb;
        n_bit_cnt     = bc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_mode  <= MODE_32;
            r_pend_first  <= '0;
            r_pend_second <= '0;
            r_pend_valid  <= 1'b0;
            r_ctrl_bits   <= '0;
            r_bit_cnt     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_width_mode <= i_cfg_mode;
            end
            if (i_accept) begin
                r_pend_first  <= n_pend_first;
                r_pend_second <= n_pend_second;
                r_pend_valid  <= n_pend_valid;
                r_ctrl_bits   <= n_ctrl_bits;
                r_bit_cnt     <= n_bit_cnt;
            end
        end
    end

    // a closing record always produces at least one result
    a_last_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_record) |-> (o_list.cnt != '0))
        else $error("last record produced no result");

    // the pending record and packer are back at their reset state after a closing record
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_record) |=> (!r_pend_valid && r_bit_cnt == '0 && r_ctrl_bits == '0))
        else $error("state not cleared after last record");

    // an empty packing byte (bit count zero) holds no set control bits
    a_ctrl_low_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bit_cnt == '0) |-> (r_ctrl_bits == '0))
        else $error("stale control bits with empty byte");

endmodule

// File: hw/rtl/swpe_resq.sv
// Result bank (one request's results) draining into the output register.
// Depends on swpe_pkg.
module swpe_resq import swpe_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  t_res_list        i_list,
    output logic             o_in_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output t_res             o_res
);

    t_res [RES_MAX-1:0] r_ent;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_idx;
    t_res               r_out;
    logic               r_out_vld;

    logic             bank_has;
    logic             take;
    logic             move;
    logic [CNT_W-1:0] rem;

    assign bank_has   = (r_idx != r_cnt);
    assign take       = r_out_vld && i_ready;
    assign move       = bank_has && (!r_out_vld || take);
    assign rem        = r_cnt - r_idx;
    // take a new request once the bank is empty or hands off its last entry now
    assign o_in_ready = !bank_has || ((rem == CNT_W'(1)) && move);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_accept) begin
                r_cnt <= i_list.cnt;
                r_idx <= '0;
            end else if (move) begin
                r_idx <= r_idx + 1'b1;
            end
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_ent <= i_list.ent;
        end
        if (move) begin
            r_out <= r_ent[r_idx[IDX_W-1:0]];
        end
    end

    assign o_valid = r_out_vld;
    assign o_res   = r_out;

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx <= r_cnt) && (r_cnt <= CNT_W'(RES_MAX)))
        else $error("result bank index out of range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |-> (!bank_has || (rem == CNT_W'(1) && move)))
        else $error("request accepted over undelivered results");

    a_drain_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !move) |=> !r_out_vld)
        else $error("output stayed valid after being taken with no refill");

endmodule

// File: hw/rtl/swapped_pair_field_encoder_unit.sv
// Top level of the swapped-pair field encoder.
// Depends on swpe_pkg, swpe_in_if, swpe_out_if, swpe_cfg_if, swpe_core, swpe_resq.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------------
//  i_in     | in  | valid/ready        | first_value, second_value, last_record
//  o_out    | out | valid/ready        | kind, value, final_res
//  i_cfg    | in  | valid/ready (rdy=1)| width_mode
//
//  A request is folded into the pairing state in its accept cycle and yields 0..4
//  results, which leave one per cycle through the output register while o_out.ready
//  is high. Requests are paced by the single output port; a new request is taken in
//  the cycle the previous request's last result moves to the output register, even
//  while that result waits.
//  Reset (i_rst_n low, synchronous) clears pending record, packer and queues;
//  width_mode returns to 32-bit. o_out.ready low stalls the bank and then i_in.
module swapped_pair_field_encoder_unit import swpe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swpe_in_if.sink     i_in,
    swpe_out_if.source  o_out,
    swpe_cfg_if.sink    i_cfg
);

    t_res_list list;
    t_res      res;
    logic      in_ready;
    logic      accept;

    assign accept      = i_in.valid && in_ready;
    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    swpe_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_mode     (i_cfg.width_mode),
        .i_accept       (accept),
        .i_first_value  (i_in.first_value),
        .i_second_value (i_in.second_value),
        .i_last_record  (i_in.last_record),
        .o_list         (list)
    );

    swpe_resq u_resq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_list     (list),
        .o_in_ready (in_ready),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_res      (res)
    );

    assign o_out.kind      = res.kind;
    assign o_out.value     = res.value;
    assign o_out.final_res = res.final_res;

endmodule
